// ----- hdl/cau_pkg.sv -----
// Shared definitions for the complex arithmetic unit: opcodes, internal
// operation kinds and default widths. No dependencies.
`default_nettype none

package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int MODE_W         = 3;

  // Opcodes on in_tuser; codes 6 and 7 give a zero result with no flags.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MULT = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_NEG  = 3'd4,
    MODE_MAG  = 3'd5
  } mode_t;

  // What the iteration stages do with one result part.
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,  // value is final
    KIND_TRUNC = 2'd1,  // drop fraction bits of a product sum
    KIND_DIV   = 2'd2,  // fractional restoring divide
    KIND_SQRT  = 2'd3   // digit-by-digit integer square root
  } kind_t;

endpackage

`default_nettype wire

// ----- hdl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit top level: fully pipelined add, sub, mult, div,
// negate and magnitude on signed fixed-point complex operands.
// Depends on cau_pkg.
`default_nettype none

// Usage
//   Input channel (in_*): one transfer carries an opcode on in_tuser and the
//   two complex operands on in_tdata. Output channel (out_*): one transfer
//   per input, in order, with the result on out_tdata and the status flags
//   (div_zero, saturated) on out_tuser.
//   Results pass through one multiply stage, one sum stage, one divide/root
//   setup stage, DATA_WIDTH + 1 stages of one quotient bit each (one root bit
//   each in the first DATA_WIDTH of them), and the output register. The
//   divide and square-root chains set that depth.
//   Throughput is one transfer per cycle unless the receiver stalls. Every
//   stage carries a valid bit and loads whenever it is empty or the stage
//   after it moves, so bubbles are squeezed out and in_tready stays high
//   while the output holds a result and empty stages remain.
//   When the receiver stalls, the output register holds its result and the
//   pipeline fills behind it; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; in-flight items
//   are discarded.
//   Results truncate toward zero and saturate to the DATA_WIDTH range.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IN_DW     = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // in_tdata: a_re, a_im, b_re, b_im (lowest bits first), zero padded
  input  wire logic [IN_DW-1:0]  in_tdata,
  // in_tuser: mode
  input  wire logic [MODE_W-1:0] in_tuser,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // out_tdata: res_re, res_im (lowest bits first), zero padded
  output logic [OUT_DW-1:0]      out_tdata,
  // out_tuser: div_zero, saturated (lowest bit first)
  output logic [1:0]             out_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;          // product / remainder width
  localparam int QW  = W + 1;          // quotient / root width
  localparam int XW  = PW + F;         // scaled dividend width
  localparam int HW  = XW - QW;        // dividend bits above the quotient span
  localparam int NIT = W + 1;          // iteration stages
  localparam int NST = NIT + 4;        // total register stages
  localparam int ST_INIT = 2;          // stage index of the setup stage
  localparam logic [QW-1:0] LIM  = {2'b01, {(W-1){1'b0}}};
  localparam logic [W-1:0]  MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINN = {1'b1, {(W-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Flow control: a stage loads when empty or when the next one moves.
  // ---------------------------------------------------------------------
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  logic           in_accept;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_accept;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: operand products and linear results
  // ---------------------------------------------------------------------
  logic signed [W-1:0] a_re, a_im, b_re, b_im;
  mode_t               mode;

  assign a_re = in_tdata[W-1:0];
  assign a_im = in_tdata[2*W-1:W];
  assign b_re = in_tdata[3*W-1:2*W];
  assign b_im = in_tdata[4*W-1:3*W];
  assign mode = mode_t'(in_tuser);

  mode_t                s1_mode_r;
  logic signed [PW-1:0] s1_p_r   [6];
  logic signed [PW-1:0] s1_p_nxt [6];
  logic signed [W:0]    s1_lin_re_r, s1_lin_im_r, s1_lin_re_nxt, s1_lin_im_nxt;

  always_comb begin
    // magnitude reuses the first two multipliers for a_re^2 and a_im^2
    s1_p_nxt[0] = PW'(a_re) * PW'((mode == MODE_MAG) ? a_re : b_re);
    s1_p_nxt[1] = PW'(a_im) * PW'((mode == MODE_MAG) ? a_im : b_im);
    s1_p_nxt[2] = PW'(a_re) * PW'(b_im);
    s1_p_nxt[3] = PW'(a_im) * PW'(b_re);
    s1_p_nxt[4] = PW'(b_re) * PW'(b_re);
    s1_p_nxt[5] = PW'(b_im) * PW'(b_im);
    unique case (mode)
      MODE_ADD: begin
        s1_lin_re_nxt = {a_re[W-1], a_re} + {b_re[W-1], b_re};
        s1_lin_im_nxt = {a_im[W-1], a_im} + {b_im[W-1], b_im};
      end
      MODE_SUB: begin
        s1_lin_re_nxt = {a_re[W-1], a_re} - {b_re[W-1], b_re};
        s1_lin_im_nxt = {a_im[W-1], a_im} - {b_im[W-1], b_im};
      end
      MODE_NEG: begin
        s1_lin_re_nxt = '0 - {a_re[W-1], a_re};
        s1_lin_im_nxt = '0 - {a_im[W-1], a_im};
      end
      default: begin
        s1_lin_re_nxt = '0;
        s1_lin_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_mode_r   <= mode;
      s1_p_r      <= s1_p_nxt;
      s1_lin_re_r <= s1_lin_re_nxt;
      s1_lin_im_r <= s1_lin_im_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: product sums, sign/magnitude split, per-part operation kind
  // ---------------------------------------------------------------------
  logic            s2_neg_r  [2], s2_neg_nxt  [2];
  logic [PW-1:0]   s2_mag_r  [2], s2_mag_nxt  [2];
  kind_t           s2_kind_r [2], s2_kind_nxt [2];
  logic [PW-1:0]   s2_d_r, s2_d_nxt;
  logic            s2_dz_r, s2_dz_nxt;

  always_comb begin
    logic signed [PW:0] sum_re, sum_im;
    logic signed [PW:0] p0, p1, p2, p3;
    logic [PW:0]        den;
    logic [PW:0]        abs_re, abs_im;
    logic [W:0]         lin_abs_re, lin_abs_im;
    p0 = (PW+1)'(s1_p_r[0]);
    p1 = (PW+1)'(s1_p_r[1]);
    p2 = (PW+1)'(s1_p_r[2]);
    p3 = (PW+1)'(s1_p_r[3]);
    sum_re = (s1_mode_r == MODE_MULT) ? p0 - p1 : p0 + p1;
    sum_im = (s1_mode_r == MODE_MULT) ? p2 + p3 : p3 - p2;
    den    = {1'b0, s1_p_r[4]} + {1'b0, s1_p_r[5]};
    abs_re = sum_re[PW] ? -sum_re : sum_re;
    abs_im = sum_im[PW] ? -sum_im : sum_im;
    lin_abs_re = s1_lin_re_r[W] ? -s1_lin_re_r : s1_lin_re_r;
    lin_abs_im = s1_lin_im_r[W] ? -s1_lin_im_r : s1_lin_im_r;
    s2_d_nxt  = den[PW-1:0];
    s2_dz_nxt = 1'b0;
    s2_neg_nxt[0]  = 1'b0;
    s2_neg_nxt[1]  = 1'b0;
    s2_mag_nxt[0]  = '0;
    s2_mag_nxt[1]  = '0;
    s2_kind_nxt[0] = KIND_PASS;
    s2_kind_nxt[1] = KIND_PASS;
    unique case (s1_mode_r)
      MODE_ADD, MODE_SUB, MODE_NEG: begin
        s2_neg_nxt[0] = s1_lin_re_r[W];
        s2_neg_nxt[1] = s1_lin_im_r[W];
        s2_mag_nxt[0] = PW'(lin_abs_re);
        s2_mag_nxt[1] = PW'(lin_abs_im);
      end
      MODE_MULT: begin
        s2_neg_nxt[0]  = sum_re[PW];
        s2_neg_nxt[1]  = sum_im[PW];
        s2_mag_nxt[0]  = abs_re[PW-1:0];
        s2_mag_nxt[1]  = abs_im[PW-1:0];
        s2_kind_nxt[0] = KIND_TRUNC;
        s2_kind_nxt[1] = KIND_TRUNC;
      end
      MODE_DIV: begin
        if (den == '0) begin
          s2_dz_nxt = 1'b1;
        end else begin
          s2_neg_nxt[0]  = sum_re[PW];
          s2_neg_nxt[1]  = sum_im[PW];
          s2_mag_nxt[0]  = abs_re[PW-1:0];
          s2_mag_nxt[1]  = abs_im[PW-1:0];
          s2_kind_nxt[0] = KIND_DIV;
          s2_kind_nxt[1] = KIND_DIV;
        end
      end
      MODE_MAG: begin
        s2_mag_nxt[0]  = sum_re[PW-1:0];
        s2_kind_nxt[0] = KIND_SQRT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_neg_r  <= s2_neg_nxt;
      s2_mag_r  <= s2_mag_nxt;
      s2_kind_r <= s2_kind_nxt;
      s2_d_r    <= s2_d_nxt;
      s2_dz_r   <= s2_dz_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3 (index 0 of the iteration arrays): divide / root setup
  // ---------------------------------------------------------------------
  logic [PW-1:0] it_rem_r  [NIT+1][2];
  logic [PW-1:0] it_sh_r   [NIT+1][2];
  logic [QW-1:0] it_q_r    [NIT+1][2];
  logic          it_ovf_r  [NIT+1][2];
  logic          it_neg_r  [NIT+1][2];
  kind_t         it_kind_r [NIT+1][2];
  logic [PW-1:0] it_d_r    [NIT+1];
  logic          it_dz_r   [NIT+1];

  logic [PW-1:0] in_rem_nxt [2];
  logic [PW-1:0] in_sh_nxt  [2];
  logic [QW-1:0] in_q_nxt   [2];
  logic          in_ovf_nxt [2];

  always_comb begin
    logic [XW-1:0] x;
    logic [HW-1:0] hi;
    logic [PW-1:0] tv;
    for (int p = 0; p < 2; p++) begin
      x  = XW'(s2_mag_r[p]) << F;
      hi = x[XW-1:QW];
      tv = s2_mag_r[p] >> F;
      in_rem_nxt[p] = '0;
      in_sh_nxt[p]  = '0;
      in_q_nxt[p]   = '0;
      in_ovf_nxt[p] = 1'b0;
      unique case (s2_kind_r[p])
        KIND_DIV: begin
          // quotient needs more than QW bits: saturates
          in_ovf_nxt[p] = (XW+1)'(hi) >= (XW+1)'(s2_d_r);
          in_rem_nxt[p] = PW'(hi);
          in_sh_nxt[p]  = {x[QW-1:0], {(PW-QW){1'b0}}};
        end
        KIND_SQRT: begin
          in_sh_nxt[p] = s2_mag_r[p];
        end
        KIND_TRUNC: begin
          in_ovf_nxt[p] = |tv[PW-1:QW];
          in_q_nxt[p]   = tv[QW-1:0];
        end
        KIND_PASS: begin
          in_ovf_nxt[p] = |s2_mag_r[p][PW-1:QW];
          in_q_nxt[p]   = s2_mag_r[p][QW-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_INIT]) begin
      it_rem_r[0]  <= in_rem_nxt;
      it_sh_r[0]   <= in_sh_nxt;
      it_q_r[0]    <= in_q_nxt;
      it_ovf_r[0]  <= in_ovf_nxt;
      it_neg_r[0]  <= s2_neg_r;
      it_kind_r[0] <= s2_kind_r;
      it_d_r[0]    <= s2_d_r;
      it_dz_r[0]   <= s2_dz_r;
    end
  end

  // ---------------------------------------------------------------------
  // Iteration stages: one quotient bit or one root bit per stage
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < NIT; j++) begin : g_iter
    logic [PW-1:0] rem_nxt [2];
    logic [PW-1:0] sh_nxt  [2];
    logic [QW-1:0] q_nxt   [2];

    always_comb begin
      logic [PW:0]   t1;
      logic [PW+1:0] t2;
      logic [PW+1:0] trial;
      logic          ge;
      for (int p = 0; p < 2; p++) begin
        rem_nxt[p] = it_rem_r[j][p];
        sh_nxt[p]  = it_sh_r[j][p];
        q_nxt[p]   = it_q_r[j][p];
        t1    = {it_rem_r[j][p], it_sh_r[j][p][PW-1]};
        t2    = {it_rem_r[j][p], it_sh_r[j][p][PW-1 -: 2]};
        trial = (PW+2)'({it_q_r[j][p], 2'b01});
        ge    = 1'b0;
        unique case (it_kind_r[j][p])
          KIND_DIV: begin
            ge         = t1 >= {1'b0, it_d_r[j]};
            rem_nxt[p] = ge ? PW'(t1 - {1'b0, it_d_r[j]}) : t1[PW-1:0];
            q_nxt[p]   = {it_q_r[j][p][QW-2:0], ge};
            sh_nxt[p]  = {it_sh_r[j][p][PW-2:0], 1'b0};
          end
          KIND_SQRT: begin
            if (j < W) begin
              ge         = t2 >= trial;
              rem_nxt[p] = ge ? PW'(t2 - trial) : t2[PW-1:0];
              q_nxt[p]   = {it_q_r[j][p][QW-2:0], ge};
              sh_nxt[p]  = {it_sh_r[j][p][PW-3:0], 2'b00};
            end
          end
          KIND_PASS, KIND_TRUNC: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_INIT+1+j]) begin
        it_rem_r[j+1]  <= rem_nxt;
        it_sh_r[j+1]   <= sh_nxt;
        it_q_r[j+1]    <= q_nxt;
        it_ovf_r[j+1]  <= it_ovf_r[j];
        it_neg_r[j+1]  <= it_neg_r[j];
        it_kind_r[j+1] <= it_kind_r[j];
        it_d_r[j+1]    <= it_d_r[j];
        it_dz_r[j+1]   <= it_dz_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: sign restore and saturation
  // ---------------------------------------------------------------------
  logic [W-1:0] res_r   [2], res_nxt [2];
  logic         sat_r, sat_nxt;
  logic         dz_r;

  always_comb begin
    logic [QW-1:0] q;
    logic          clip;
    sat_nxt = 1'b0;
    for (int p = 0; p < 2; p++) begin
      q = it_q_r[NIT][p];
      if (it_neg_r[NIT][p]) begin
        clip       = it_ovf_r[NIT][p] || (q > LIM);
        res_nxt[p] = clip ? MINN : W'('0 - q);
      end else begin
        clip       = it_ovf_r[NIT][p] || (q >= LIM);
        res_nxt[p] = clip ? MAXP : q[W-1:0];
      end
      sat_nxt = sat_nxt || clip;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
      dz_r  <= it_dz_r[NIT];
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = OUT_DW'({res_r[1], res_r[0]});
  assign out_tuser  = {sat_r, dz_r};

endmodule

`default_nettype wire

// ----- hdl/cau_checker.sv -----
// Port-level checker for the complex arithmetic unit, bound to the top level.
// No package dependency.
`default_nettype none

module cau_checker #(
  parameter int DATA_WIDTH = 16,
  parameter int OUT_DW     = 32
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic [1:0]        out_tuser,
  input wire logic              out_tvalid,
  input wire logic              out_tready
);

  // a result held back by the receiver stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped during stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed during stall");

  // zero divisor: zero result, no saturation
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[2*DATA_WIDTH-1:0] == '0) && !out_tuser[1])
    else $error("div_zero with nonzero result or saturation");

  // an empty output register means the pipeline can always take input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind complex_arithmetic_unit cau_checker #(
  .DATA_WIDTH(DATA_WIDTH),
  .OUT_DW    (OUT_DW)
) u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);

`default_nettype wire

// ----- tb/tb_complex_arithmetic_unit.sv -----
// Testbench for complex_arithmetic_unit: directed and random operations with a
// self-checking predictor and an in-order scoreboard class.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] re;
  logic [15:0] im;
  logic        dz;
  logic        sat;
} cplx_res_t;

class cplx_scoreboard;
  cplx_res_t pending[$];
  int unsigned mismatches;

  function void note_op(cplx_res_t r);
    pending.push_back(r);
  endfunction

  function void check_res(cplx_res_t got);
    cplx_res_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result re=%h im=%h", got.re, got.im);
      return;
    end
    want = pending.pop_front();
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: exp re=%h im=%h dz=%b sat=%b, got re=%h im=%h dz=%b sat=%b",
                 want.re, want.im, want.dz, want.sat, got.re, got.im, got.dz, got.sat);
    end
  endfunction
endclass

module tb_complex_arithmetic_unit
  import cau_pkg::*;
();

  localparam int W = 16;
  localparam int FB = 8;
  localparam int LATENCY = W + 5;
  localparam longint LIM_POS = (64'sd1 <<< (W - 1)) - 1;
  localparam longint LIM_NEG = -(64'sd1 <<< (W - 1));

  logic        clk;
  logic        rst_n;
  logic [63:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready;

  cplx_scoreboard sb;
  int idle_pct;        // sender idle chance
  int stall_pct;       // receiver stall chance
  bit hold_off;        // long receiver hold-off in progress

  complex_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Clamp to the signed range; a flag notes saturation.
  function automatic longint clamp(longint v, ref bit sat);
    if (v > LIM_POS) begin
      sat = 1'b1;
      return LIM_POS;
    end
    if (v < LIM_NEG) begin
      sat = 1'b1;
      return LIM_NEG;
    end
    return v;
  endfunction

  // Truncate toward zero after dropping FB fraction bits.
  function automatic longint drop_frac(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >> FB;
    return (v < 0) ? -m : m;
  endfunction

  // Fractional divide toward zero: sign(n) * min(floor(|n| * 2^FB / d), 2^W).
  function automatic longint qdiv(longint n, longint d);
    longint m;
    m = (n < 0) ? -n : n;
    m = (m <<< FB) / d;
    if (m > (64'sd1 <<< W)) m = 64'sd1 <<< W;
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    for (b = 64'sd1 <<< 31; b > 0; b = b >> 1)
      if ((r + b) * (r + b) <= n) r = r + b;
    return r;
  endfunction

  function automatic cplx_res_t predict(mode_t m, logic signed [15:0] ar,
                                        logic signed [15:0] ai,
                                        logic signed [15:0] br,
                                        logic signed [15:0] bi);
    cplx_res_t r;
    bit sat;
    longint a, b, c, d, re, im, den;
    a = ar; b = ai; c = br; d = bi;
    sat = 1'b0; re = 0; im = 0;
    r.dz = 1'b0;
    case (m)
      MODE_ADD: begin
        re = clamp(a + c, sat); im = clamp(b + d, sat);
      end
      MODE_SUB: begin
        re = clamp(a - c, sat); im = clamp(b - d, sat);
      end
      MODE_MULT: begin
        re = clamp(drop_frac(a * c - b * d), sat);
        im = clamp(drop_frac(a * d + b * c), sat);
      end
      MODE_DIV: begin
        den = c * c + d * d;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = clamp(qdiv(a * c + b * d, den), sat);
          im = clamp(qdiv(b * c - a * d, den), sat);
        end
      end
      MODE_NEG: begin
        re = clamp(-a, sat); im = clamp(-b, sat);
      end
      MODE_MAG: re = clamp(int_sqrt(a * a + b * b), sat);
      default: ;
    endcase
    r.re = re[15:0];
    r.im = im[15:0];
    r.sat = sat;
    return r;
  endfunction

  // Offer one operation and wait for its transfer; valid stays high after.
  task automatic send_op(logic [2:0] m, logic [15:0] ar, logic [15:0] ai,
                         logic [15:0] br, logic [15:0] bi);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {bi, br, ai, ar};
    in_tuser  <= m;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(predict(mode_t'(m), ar, ai, br, bi));
  endtask

  // Drop valid after the last transfer of a run.
  task automatic end_run();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_ops(int n);
    logic [2:0] m;
    for (int i = 0; i < n; i++) begin
      m = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      if (m == MODE_DIV && $urandom_range(9) == 0)
        send_op(m, rand_val(), rand_val(), 16'h0000, 16'h0000);
      else
        send_op(m, rand_val(), rand_val(), rand_val(), rand_val());
    end
    end_run();
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_res('{re: out_tdata[15:0], im: out_tdata[31:16],
                     dz: out_tuser[0], sat: out_tuser[1]});
  end

  initial begin
    int waited;
    sb = new();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    idle_pct = 0; stall_pct = 0; hold_off = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all eight opcode codes, at the field extremes and with b = 1 - 1i
    for (int m = 0; m < 8; m++) begin
      send_op(3'(m), 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_op(3'(m), 16'h8000, 16'h8000, 16'h0100, 16'hff00);
    end
    send_op(MODE_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);  // zero divisor
    send_op(MODE_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);  // huge quotient
    send_op(MODE_NEG, 16'h8000, 16'h0001, 16'hffff, 16'hffff);  // negate min
    send_op(MODE_MAG, 16'h7fff, 16'h7fff, 16'h1234, 16'h5678);  // magnitude clamps
    send_op(MODE_MAG, 16'h0300, 16'h0400, 16'h0000, 16'h0000);
    send_op(MODE_MULT, 16'hffff, 16'hffff, 16'h0001, 16'h0001);
    end_run();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      random_ops(40);
      begin
        for (int c = 0; c < 200; c++) @(posedge clk);
        hold_off = 1'b0;
      end
    join

    idle_pct = 0;  stall_pct = 0;  random_ops(100);
    idle_pct = 61; stall_pct = 0;  random_ops(100);
    idle_pct = 0;  stall_pct = 61; random_ops(100);
    idle_pct = 18; stall_pct = 18; random_ops(100);

    waited = 0;
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
